// File: rtl/gda_pkg.sv
`timescale 1ns / 1ps

package gda_pkg;

   localparam int unsigned MAX_COUNT_DEF = 4095;

   localparam int COUNT_W = 12;
   localparam int STEP_W  = 15;
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [15:0] YEAR_MAX = 16'hFFFF;

   // Reciprocal of 100 scaled by 2**23, exact for every 16-bit year.
   localparam logic [MUL_B_W-1:0] RECIP_100   = 17'd83887;
   localparam int                 RECIP_SHIFT = 23;

   localparam logic [2:0] OP_DAYS      = 3'd0;
   localparam logic [2:0] OP_WEEKS     = 3'd1;
   localparam logic [2:0] OP_MONTHS    = 3'd2;
   localparam logic [2:0] OP_YEARS     = 3'd3;
   localparam logic [2:0] OP_DECADES   = 3'd4;
   localparam logic [2:0] OP_CENTURIES = 3'd5;
   localparam logic [2:0] OP_MILLENNIA = 3'd6;

   typedef struct packed {
      logic [2:0]         op;
      logic [COUNT_W-1:0] count;
      logic [4:0]         start_day;
      logic [3:0]         start_month;
      logic [15:0]        start_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  end_day;
      logic [3:0]  end_month;
      logic [15:0] end_year;
      logic        year_overflow;
      logic        bad_date;
   } rsp_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LQ,
      S_LR,
      S_CHECK,
      S_STEP,
      S_MSTEP,
      S_YMUL,
      S_YADD,
      S_CLAMP,
      S_DONE
   } state_type;

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m) inside
         4'd2:                                    len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default:                                 len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [MUL_B_W-1:0] unit_of(input logic [2:0] op);
      logic [MUL_B_W-1:0] u;
      case (op)
         OP_DECADES:   u = 17'd10;
         OP_CENTURIES: u = 17'd100;
         OP_MILLENNIA: u = 17'd1000;
         default:      u = 17'd1;
      endcase
      return u;
   endfunction

endpackage

// File: rtl/gregorian_date_adder_top.sv
`timescale 1ns / 1ps

// Channel    Ports                       Handshake
// request    start, busy, req_data       beat taken when start is high and busy is low
// response   rsp_valid, rsp_data         beat shown for one cycle, always taken
//
// Every beat first finds the leap-year flag of the start year on the shared
// multiplier and then validates the date. Day and week adds step one day per
// cycle and month adds one month per cycle, each with a closing step, pausing at
// each new year to find its leap flag again; year-type adds multiply, add, find
// the new leap flag and clamp the day. Reset is synchronous and returns the
// sequencer to idle; the receiver cannot stall, and busy stays high to the beat.

module gregorian_date_adder_top #(
   parameter int unsigned MAX_COUNT = gda_pkg::MAX_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gda_pkg::req_type req_data,
   output logic             rsp_valid,
   output gda_pkg::rsp_type rsp_data
);
   import gda_pkg::*;

   mul_req_type       mul_req;
   logic [PROD_W-1:0] prod;

   gda_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   gda_ctrl #(
      .MAX_COUNT (MAX_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .mul_req   (mul_req),
      .prod      (prod)
   );

endmodule

// File: rtl/gda_mul.sv
`timescale 1ns / 1ps

module gda_mul (
   input  logic                 clock,
   input  gda_pkg::mul_req_type mul_req,
   output logic [gda_pkg::PROD_W-1:0] prod
);
   import gda_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: rtl/gda_ctrl.sv
`timescale 1ns / 1ps

module gda_ctrl #(
   parameter int unsigned MAX_COUNT = gda_pkg::MAX_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  gda_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output gda_pkg::rsp_type            rsp_data,
   output gda_pkg::mul_req_type        mul_req,
   input  logic [gda_pkg::PROD_W-1:0]  prod
);
   import gda_pkg::*;

   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;
   logic [2:0]         op_ff, op_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [4:0]         d_ff, d_in;
   logic [3:0]         m_ff, m_in;
   logic [15:0]        y_ff, y_in;
   logic               ovf_ff, ovf_in;
   logic               bad_ff, bad_in;
   logic               leap_ff, leap_in;
   logic [STEP_W-1:0]  rem_ff, rem_in;

   logic [4:0]         cur_len;
   logic [4:0]         next_len;
   logic [3:0]         m_next;
   logic               date_ok;
   logic               at_month_end;
   logic               at_year_end;
   logic               at_top;
   logic               rem_zero;
   logic [9:0]         cent_q;
   logic [16:0]        cent_y;
   logic [22:0]        year_sum;
   logic               sum_ovf;
   logic [COUNT_W-1:0] cnt_sat;

   assign cur_len      = days_in(m_ff, leap_ff);
   assign m_next       = m_ff + 4'd1;
   assign next_len     = days_in(m_next, leap_ff);
   assign date_ok      = (d_ff != 5'd0) && (d_ff <= cur_len);
   assign at_month_end = (d_ff == cur_len);
   assign at_year_end  = (m_ff == 4'd12);
   assign at_top       = (y_ff == YEAR_MAX);
   assign rem_zero     = (rem_ff == '0);

   assign cent_q   = prod[RECIP_SHIFT +: 10];
   assign cent_y   = 17'({cent_q, 6'b0}) + 17'({cent_q, 5'b0}) + 17'({cent_q, 2'b0});
   assign year_sum = 23'(y_ff) + prod[22:0];
   assign sum_ovf  = (year_sum[22:16] != '0);
   assign cnt_sat  = (17'(req_data.count) > 17'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT)
                                                            : req_data.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      y_ff    <= y_in;
      ovf_ff  <= ovf_in;
      bad_ff  <= bad_in;
      leap_ff <= leap_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_LQ;
         S_LQ:    state_in = S_LR;
         S_LR:    state_in = ret_ff;
         S_CHECK: begin
            if (!date_ok) begin
               state_in = S_DONE;
            end else begin
               case (op_ff) inside
                  OP_DAYS, OP_WEEKS: state_in = S_STEP;
                  OP_MONTHS:         state_in = S_MSTEP;
                  OP_YEARS, OP_DECADES, OP_CENTURIES, OP_MILLENNIA: state_in = S_YMUL;
                  default:           state_in = S_DONE;
               endcase
            end
         end
         S_STEP: begin
            if (rem_zero) begin
               state_in = S_DONE;
            end else if (at_month_end && at_year_end) begin
               state_in = at_top ? S_DONE : S_LQ;
            end
         end
         S_MSTEP: begin
            if (rem_zero) begin
               state_in = S_DONE;
            end else if (at_year_end) begin
               state_in = at_top ? S_DONE : S_LQ;
            end
         end
         S_YMUL:  state_in = S_YADD;
         S_YADD:  state_in = S_LQ;
         S_CLAMP: state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ret_in    = ret_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      d_in      = d_ff;
      m_in      = m_ff;
      y_in      = y_ff;
      ovf_in    = ovf_ff;
      bad_in    = bad_ff;
      leap_in   = leap_ff;
      rem_in    = rem_ff;
      mul_req.a = y_ff;
      mul_req.b = RECIP_100;
      busy      = (state_ff != S_IDLE);
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_data.op;
               cnt_in = cnt_sat;
               d_in   = req_data.start_day;
               m_in   = req_data.start_month;
               y_in   = req_data.start_year;
               ovf_in = 1'b0;
               bad_in = 1'b0;
               ret_in = S_CHECK;
            end
         end
         S_LQ: begin
            mul_req.a = y_ff;
            mul_req.b = RECIP_100;
         end
         S_LR: begin
            leap_in = (y_ff[1:0] == 2'b00) &&
                      ((17'(y_ff) != cent_y) || (cent_q[1:0] == 2'b00));
         end
         S_CHECK: begin
            bad_in = !date_ok;
            if (op_ff == OP_WEEKS) begin
               rem_in = STEP_W'({cnt_ff, 3'b000}) - STEP_W'(cnt_ff);
            end else begin
               rem_in = STEP_W'(cnt_ff);
            end
         end
         S_STEP: begin
            if (!rem_zero) begin
               rem_in = rem_ff - STEP_W'(1);
               if (!at_month_end) begin
                  d_in = d_ff + 5'd1;
               end else if (!at_year_end) begin
                  d_in = 5'd1;
                  m_in = m_next;
               end else if (at_top) begin
                  d_in   = 5'd31;
                  m_in   = 4'd12;
                  ovf_in = 1'b1;
               end else begin
                  d_in   = 5'd1;
                  m_in   = 4'd1;
                  y_in   = y_ff + 16'd1;
                  ret_in = S_STEP;
               end
            end
         end
         S_MSTEP: begin
            if (!rem_zero) begin
               rem_in = rem_ff - STEP_W'(1);
               if (!at_year_end) begin
                  m_in = m_next;
                  if (d_ff > next_len) d_in = next_len;
               end else if (at_top) begin
                  d_in   = 5'd31;
                  m_in   = 4'd12;
                  ovf_in = 1'b1;
               end else begin
                  m_in   = 4'd1;
                  y_in   = y_ff + 16'd1;
                  ret_in = S_MSTEP;
               end
            end
         end
         S_YMUL: begin
            mul_req.a = MUL_A_W'(cnt_ff);
            mul_req.b = unit_of(op_ff);
         end
         S_YADD: begin
            ovf_in = sum_ovf;
            y_in   = sum_ovf ? YEAR_MAX : year_sum[15:0];
            ret_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (d_ff > cur_len) d_in = cur_len;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_data.end_day       = d_ff;
   assign rsp_data.end_month     = m_ff;
   assign rsp_data.end_year      = y_ff;
   assign rsp_data.year_overflow = ovf_ff;
   assign rsp_data.bad_date      = bad_ff;

endmodule

// File: dv/gregorian_date_adder_top_test.sv
`timescale 1ns / 1ps

module gregorian_date_adder_top_test;
   import gda_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int unsigned NUM_RANDOM = 100;

   typedef struct {
      req_type beat;
      bit      drain_first;
   } queued_request;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   queued_request pending_requests[$];
   rsp_type       expected_dates[$];
   int unsigned   gap_left = 0;
   logic          beat_taken = 1'b0;
   int unsigned   mismatch_count = 0;
   longint        cycle_count = 0;
   longint        cycle_limit = 20000;

   gregorian_date_adder_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_length(int unsigned m, int unsigned y);
      case (m)
         2:             return is_leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:       return 0;
      endcase
   endfunction

   function automatic rsp_type add_to_date(req_type r);
      int unsigned d, m, y, steps, unit, len, total;
      logic        ovf, bad;
      rsp_type     res;
      d = 32'(r.start_day);
      m = 32'(r.start_month);
      y = 32'(r.start_year);
      ovf = 1'b0;
      bad = 1'b0;
      steps = (32'(r.count) > MAX_COUNT_DEF) ? MAX_COUNT_DEF : 32'(r.count);
      if (m < 1 || m > 12 || d < 1 || d > month_length(m, y)) begin
         bad = 1'b1;
      end else if (r.op == OP_DAYS || r.op == OP_WEEKS) begin
         if (r.op == OP_WEEKS) steps = steps * 7;
         for (int unsigned i = 0; i < steps; i++) begin
            if (d == month_length(m, y)) begin
               d = 1;
               if (m == 12) begin
                  if (y == YEAR_MAX) begin
                     d = 31;
                     ovf = 1'b1;
                     break;
                  end
                  m = 1;
                  y++;
               end else begin
                  m++;
               end
            end else begin
               d++;
            end
         end
      end else if (r.op == OP_MONTHS) begin
         for (int unsigned i = 0; i < steps; i++) begin
            if (m == 12) begin
               if (y == YEAR_MAX) begin
                  d = 31;
                  ovf = 1'b1;
                  break;
               end
               m = 1;
               y++;
            end else begin
               m++;
            end
            len = month_length(m, y);
            if (d > len) d = len;
         end
      end else if (r.op != OP_UNUSED) begin
         case (r.op)
            OP_DECADES:   unit = 10;
            OP_CENTURIES: unit = 100;
            OP_MILLENNIA: unit = 1000;
            default:      unit = 1;
         endcase
         total = y + steps * unit;
         if (total > 32'(YEAR_MAX)) begin
            total = 32'(YEAR_MAX);
            ovf = 1'b1;
         end
         y = total;
         len = month_length(m, y);
         if (d > len) d = len;
      end
      res.end_day       = d[4:0];
      res.end_month     = m[3:0];
      res.end_year      = y[15:0];
      res.year_overflow = ovf;
      res.bad_date      = bad;
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic queue_request(logic [2:0] op, int unsigned count, int unsigned day,
                                int unsigned month, int unsigned year, bit drain);
      queued_request q;
      int unsigned   steps;
      q.beat.op          = op;
      q.beat.count       = count[COUNT_W-1:0];
      q.beat.start_day   = day[4:0];
      q.beat.start_month = month[3:0];
      q.beat.start_year  = year[15:0];
      q.drain_first      = drain;
      pending_requests.push_back(q);
      steps = (op == OP_WEEKS) ? 32'(q.beat.count) * 7 :
              (op == OP_DAYS || op == OP_MONTHS) ? 32'(q.beat.count) : 0;
      cycle_limit += 4 * (100 + 2 * steps);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Driver: a held beat stays until taken, then the next one follows after a random gap, possibly none.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (gap_left != 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_dates.size() != 0)) begin
            req_data <= pending_requests[0].beat;
            start <= 1'b1;
            gap_left <= pick_gap();
            void'(pending_requests.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         if (start && !busy) expected_dates.push_back(add_to_date(req_data));
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               report_mismatch("unexpected response beat", 32'(rsp_data), 32'(0));
            end else begin
               want = expected_dates.pop_front();
               compare_field("end_day", 32'(rsp_data.end_day), 32'(want.end_day));
               compare_field("end_month", 32'(rsp_data.end_month), 32'(want.end_month));
               compare_field("end_year", 32'(rsp_data.end_year), 32'(want.end_year));
               compare_field("year_overflow", 32'(rsp_data.year_overflow),
                             32'(want.year_overflow));
               compare_field("bad_date", 32'(rsp_data.bad_date), 32'(want.bad_date));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("FAIL gregorian_date_adder_top");
         $finish;
      end
   end

   initial begin
      int unsigned roll, op_roll, yr, mo, dy, cnt;
      logic [2:0]  op;

      queue_request(OP_DAYS,      0,    15,  6, 2024,  1'b0);
      queue_request(OP_DAYS,      1,    31, 12, 2023,  1'b0);
      queue_request(OP_DAYS,      1,    28,  2, 1900,  1'b0);
      queue_request(OP_DAYS,      1,    28,  2, 2000,  1'b0);
      queue_request(OP_DAYS,      4095,  1,  1, 0,     1'b0);
      queue_request(OP_WEEKS,     4095, 29,  2, 2024,  1'b0);
      queue_request(OP_WEEKS,     1,    25, 12, 65535, 1'b1);
      queue_request(OP_DAYS,      1,    31, 12, 65535, 1'b0);
      queue_request(OP_MONTHS,    1,    31,  1, 2023,  1'b0);
      queue_request(OP_MONTHS,    4095, 31,  3, 2000,  1'b0);
      queue_request(OP_MONTHS,    1,    15, 12, 65535, 1'b0);
      queue_request(OP_YEARS,     1,    29,  2, 2024,  1'b0);
      queue_request(OP_YEARS,     4095,  1,  1, 61440, 1'b1);
      queue_request(OP_DECADES,   4095, 10, 10, 100,   1'b0);
      queue_request(OP_CENTURIES, 1,    29,  2, 1600,  1'b0);
      queue_request(OP_MILLENNIA, 65,   29,  2, 0,     1'b0);
      queue_request(OP_MILLENNIA, 66,    3,  3, 1000,  1'b0);
      queue_request(OP_MILLENNIA, 4095, 31, 12, 65535, 1'b0);
      queue_request(OP_UNUSED,    100,   5,  5, 5,     1'b0);
      queue_request(OP_DAYS,      3,     1,  0, 2020,  1'b0);
      queue_request(OP_MONTHS,    3,    31, 15, 2020,  1'b0);
      queue_request(OP_YEARS,     3,    31, 13, 2020,  1'b0);
      queue_request(OP_WEEKS,     3,     0,  7, 2020,  1'b0);
      queue_request(OP_DAYS,      1,    29,  2, 2023,  1'b0);
      queue_request(OP_DAYS,      1,    31,  4, 2020,  1'b0);
      queue_request(OP_DAYS,      1,    30,  2, 2024,  1'b0);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         op_roll = $urandom_range(0, 99);
         op = (op_roll < 5) ? OP_UNUSED : 3'($urandom_range(OP_DAYS, OP_MILLENNIA));
         roll = $urandom_range(0, 99);
         if (roll < 75) yr = $urandom_range(0, YEAR_MAX);
         else if (roll < 90) yr = $urandom_range(YEAR_MAX - 35, YEAR_MAX);
         else yr = $urandom_range(1580, 2500);
         if ($urandom_range(0, 99) < 90) begin
            mo = $urandom_range(1, 12);
            dy = $urandom_range(1, month_length(mo, yr));
         end else begin
            mo = $urandom_range(0, 15);
            dy = $urandom_range(0, 31);
         end
         roll = $urandom_range(0, 99);
         if (op == OP_DAYS || op == OP_WEEKS || op == OP_MONTHS) begin
            if (roll < 75) cnt = $urandom_range(0, 40);
            else if (roll < 95) cnt = $urandom_range(0, 500);
            else cnt = $urandom_range(0, MAX_COUNT_DEF);
         end else begin
            cnt = (roll < 60) ? $urandom_range(0, 60) : $urandom_range(0, MAX_COUNT_DEF);
         end
         queue_request(op, cnt, dy, mo, yr, n == 0 || n == NUM_RANDOM / 2);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_dates.size() != 0);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS gregorian_date_adder_top");
      end else begin
         $display("FAIL gregorian_date_adder_top");
      end
      $finish;
   end

endmodule

// File: gregorian_date_adder_top.f
rtl/gda_pkg.sv
rtl/gda_mul.sv
rtl/gda_ctrl.sv
rtl/gregorian_date_adder_top.sv
dv/gregorian_date_adder_top_test.sv
